@@ rtl/frr_pkg.sv @@
// ----------------------------------------------------------------------------
// frr_pkg
// Shared types and limits for the fragment record reassembler.
// ----------------------------------------------------------------------------
package frr_pkg;

    // frame and record limits
    localparam logic [3:0] FRAME_BYTES      = 4'd8;
    localparam logic [7:0] MAX_FRAGMENTS    = 8'd32;
    localparam logic [9:0] MAX_RECORD_BYTES = 10'd256;

    // record store: two banks of 8-byte rows, even and odd rows
    localparam int unsigned BANK_ROWS = 16;
    localparam int unsigned BANK_AW   = 4;

    // command queue between front and back
    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned CMDQ_AW    = 2;
    localparam int unsigned CMDQ_CW    = 3;

    typedef enum logic [1:0] {
        ST_REJECTED   = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_COMPLETE   = 2'd2,
        ST_ABORT      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        logic        cmd;
        logic        is_start;
        logic        is_end;
        logic [7:0]  frag_seq;
        logic [3:0]  byte_count;
        logic [63:0] payload;
    } t_frame_in;

    typedef struct packed {
        t_status     status;
        logic        abandoned;
        logic [8:0]  record_length;
        logic [4:0]  word_index;
        logic [63:0] record_word;
        logic        last;
    } t_result;

    // classified work for the back end
    typedef struct packed {
        t_status     status;
        logic        abandoned;
        logic        wr;
        logic [7:0]  wr_pos;
        logic [3:0]  wr_len;
        logic [63:0] payload;
        logic [8:0]  rec_len;
    } t_cmd;

endpackage

@@ rtl/frr_front.sv @@
// ----------------------------------------------------------------------------
// frr_front
// Checks each frame against the record state and turns it into a command.
// ----------------------------------------------------------------------------
module frr_front
    import frr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_frame_in i_frame,
    output logic      o_cmd_push,
    output t_cmd      o_cmd,
    input  logic      i_cmd_full
);

    logic       r_open;
    logic [8:0] r_bytes_held;
    logic [5:0] r_expected;
    logic       n_open;
    logic [8:0] n_bytes_held;
    logic [5:0] n_expected;

    logic       open_eff;
    logic [8:0] held_eff;
    logic [5:0] exp_eff;
    logic [9:0] sum;
    logic       viol;

    assign full       = i_cmd_full;
    assign o_cmd_push = push && !i_cmd_full;

    always_comb begin
        open_eff = i_frame.is_start ? 1'b1 : r_open;
        held_eff = i_frame.is_start ? 9'd0 : r_bytes_held;
        exp_eff  = i_frame.is_start ? 6'd0 : r_expected;
        sum      = {1'b0, held_eff} + {6'd0, i_frame.byte_count};
        viol     = (i_frame.frag_seq >= MAX_FRAGMENTS) || !open_eff ||
                   ({2'b00, exp_eff} != i_frame.frag_seq) ||
                   (i_frame.byte_count > FRAME_BYTES) ||
                   (sum > MAX_RECORD_BYTES);

        o_cmd.status    = ST_REJECTED;
        o_cmd.abandoned = i_frame.is_start && r_open;
        o_cmd.wr        = 1'b0;
        o_cmd.wr_pos    = held_eff[7:0];
        o_cmd.wr_len    = i_frame.byte_count;
        o_cmd.payload   = i_frame.payload;
        o_cmd.rec_len   = sum[8:0];

        n_open       = 1'b0;
        n_bytes_held = 9'd0;
        n_expected   = 6'd0;

        if (i_frame.cmd) begin
            o_cmd.status    = ST_ABORT;
            o_cmd.abandoned = r_open;
        end else if (i_frame.is_start && (i_frame.frag_seq != 8'd0)) begin
            o_cmd.status = ST_REJECTED;
        end else if (viol) begin
            o_cmd.status    = ST_REJECTED;
            o_cmd.abandoned = (i_frame.is_start && r_open) || open_eff;
        end else begin
            o_cmd.wr = 1'b1;
            if (i_frame.is_end) begin
                o_cmd.status = ST_COMPLETE;
            end else begin
                o_cmd.status = ST_INCOMPLETE;
                n_open       = 1'b1;
                n_bytes_held = sum[8:0];
                n_expected   = exp_eff + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open       <= 1'b0;
            r_bytes_held <= 9'd0;
            r_expected   <= 6'd0;
        end else if (o_cmd_push) begin
            r_open       <= n_open;
            r_bytes_held <= n_bytes_held;
            r_expected   <= n_expected;
        end
    end

endmodule

@@ rtl/frr_cmdq.sv @@
// ----------------------------------------------------------------------------
// frr_cmdq
// Small command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module frr_cmdq
    import frr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd               r_entry [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wr_ptr;
    logic [CMDQ_AW-1:0] r_rd_ptr;
    logic [CMDQ_CW-1:0] r_count;
    logic [CMDQ_CW-1:0] n_count;

    assign o_full  = (r_count == CMDQ_CW'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_entry[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CMDQ_CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CMDQ_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + CMDQ_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + CMDQ_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/frr_back.sv @@
// ----------------------------------------------------------------------------
// frr_back
// Writes fragment bytes into the record store and emits result transactions.
// ----------------------------------------------------------------------------
module frr_back
    import frr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_empty,
    output logic    o_cmd_pop,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    t_back_state r_state;
    t_back_state n_state;

    logic [7:0][7:0] r_bank_even [BANK_ROWS];
    logic [7:0][7:0] r_bank_odd  [BANK_ROWS];
    logic [63:0]     r_rd_even;
    logic [63:0]     r_rd_odd;

    logic [4:0] r_word;
    logic [4:0] n_word;
    logic [4:0] r_last_word;
    logic [4:0] n_last_word;
    logic [8:0] r_rec_len;
    logic [8:0] n_rec_len;
    logic       r_abandoned;
    logic       n_abandoned;
    logic       r_out_valid;
    logic       n_out_valid;
    t_result    r_out;
    t_result    n_out;

    logic         out_free;
    logic         load_out;
    logic         wr_en;
    logic         rd_en;
    logic [4:0]   wr_row;
    logic [4:0]   wr_row_next;
    logic [127:0] wr_data;
    logic [15:0]  wr_be;
    logic [8:0]   len_mask;
    logic [8:0]   rec_len_m1;
    logic [63:0]  rd_word;
    logic [63:0]  word_masked;

    logic [BANK_AW-1:0] even_addr;
    logic [63:0]        even_data;
    logic [7:0]         even_be;
    logic [BANK_AW-1:0] odd_addr;
    logic [63:0]        odd_data;
    logic [7:0]         odd_be;

    assign empty    = !r_out_valid;
    assign o_result = r_out;
    assign out_free = !r_out_valid || pop;

    // align the payload to its byte position across two adjacent rows
    always_comb begin
        wr_row      = i_cmd.wr_pos[7:3];
        wr_row_next = wr_row + 5'd1;
        len_mask    = (9'd1 << i_cmd.wr_len) - 9'd1;
        wr_data     = {64'd0, i_cmd.payload} << {i_cmd.wr_pos[2:0], 3'b000};
        wr_be       = {8'd0, len_mask[7:0]} << i_cmd.wr_pos[2:0];
        if (!wr_row[0]) begin
            even_addr = wr_row[4:1];
            even_data = wr_data[63:0];
            even_be   = wr_be[7:0];
            odd_data  = wr_data[127:64];
            odd_be    = wr_be[15:8];
        end else begin
            even_addr = wr_row_next[4:1];
            even_data = wr_data[127:64];
            even_be   = wr_be[15:8];
            odd_data  = wr_data[63:0];
            odd_be    = wr_be[7:0];
        end
        odd_addr = wr_row[4:1];
    end

    // bytes past the record length read as zero
    always_comb begin
        rd_word = r_word[0] ? r_rd_odd : r_rd_even;
        for (int b = 0; b < 8; b++) begin
            word_masked[8*b +: 8] = ({1'b0, r_word, 3'(b)} < r_rec_len) ?
                                    rd_word[8*b +: 8] : 8'd0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_last_word = r_last_word;
        n_rec_len   = r_rec_len;
        n_abandoned = r_abandoned;
        o_cmd_pop   = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        load_out    = 1'b0;
        rec_len_m1  = i_cmd.rec_len - 9'd1;

        n_out.status        = i_cmd.status;
        n_out.abandoned     = i_cmd.abandoned;
        n_out.record_length = 9'd0;
        n_out.word_index    = 5'd0;
        n_out.record_word   = 64'd0;
        n_out.last          = 1'b1;

        unique case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    if (i_cmd.status == ST_COMPLETE) begin
                        o_cmd_pop   = 1'b1;
                        wr_en       = i_cmd.wr;
                        n_word      = 5'd0;
                        n_rec_len   = i_cmd.rec_len;
                        n_abandoned = i_cmd.abandoned;
                        n_last_word = (i_cmd.rec_len == 9'd0) ? 5'd0 : rec_len_m1[7:3];
                        n_state     = BK_READ;
                    end else if (out_free) begin
                        o_cmd_pop = 1'b1;
                        wr_en     = i_cmd.wr;
                        load_out  = 1'b1;
                    end
                end
            end
            BK_READ: begin
                rd_en   = 1'b1;
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                n_out.status        = ST_COMPLETE;
                n_out.abandoned     = r_abandoned;
                n_out.record_length = r_rec_len;
                n_out.word_index    = r_word;
                n_out.record_word   = word_masked;
                n_out.last          = (r_word == r_last_word);
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_word == r_last_word) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_word  = r_word + 5'd1;
                        n_state = BK_READ;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word      <= n_word;
        r_last_word <= n_last_word;
        r_rec_len   <= n_rec_len;
        r_abandoned <= n_abandoned;
        if (load_out) begin
            r_out <= n_out;
        end
    end

    // record store, one row write per bank and one row read per bank
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int b = 0; b < 8; b++) begin
                if (even_be[b]) begin
                    r_bank_even[even_addr][b] <= even_data[8*b +: 8];
                end
                if (odd_be[b]) begin
                    r_bank_odd[odd_addr][b] <= odd_data[8*b +: 8];
                end
            end
        end
        if (rd_en) begin
            r_rd_even <= r_bank_even[r_word[4:1]];
            r_rd_odd  <= r_bank_odd[r_word[4:1]];
        end
    end

endmodule

@@ rtl/fragment_record_reassembler_core.sv @@
// Path: a single-result transaction passes the command queue and then the output register;
// a completed record is written to the store, then each word takes a registered store read
// and is loaded into the output register once that register is free. Throughput: one frame
// per cycle into a four-entry command queue while it is not full; the back end drains one
// single-result command per cycle while its output is free and takes no new one mid-record.
// Reset: synchronous active low, clears record state, queue, back-end state and output valid only.
// ----------------------------------------------------------------------------
// fragment_record_reassembler_core
// Reassembles records from numbered frame fragments and emits them as words.
// ----------------------------------------------------------------------------
module fragment_record_reassembler_core
    import frr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_frame_in i_frame,
    output logic      empty,
    input  logic      pop,
    output t_result   o_result
);

    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_full;
    logic cmd_pop;
    t_cmd cmd_head;
    logic cmd_empty;

    frr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_frame    (i_frame),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    frr_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_head),
        .o_empty (cmd_empty)
    );

    frr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule
